// ----- rtl/mhst_pkg.sv -----
package mhst_pkg;

    // Table geometry
    localparam int NUM_SQUARES = 64;
    localparam int PIECE_KINDS = 6;
    localparam int QUIET_DEPTH = 2 * PIECE_KINDS * NUM_SQUARES;
    localparam int CAP_DEPTH   = 2 * PIECE_KINDS * PIECE_KINDS;
    localparam int QIDX_W      = $clog2(QUIET_DEPTH);
    localparam int CIDX_W      = $clog2(CAP_DEPTH);

    // Field widths
    localparam int MOVE_W  = 20;
    localparam int BONUS_W = 16;
    localparam int SCORE_W = 32;
    localparam int LIMIT_W = 16;
    localparam int CODE_W  = 3;
    localparam int TGT_W   = 6;

    // Move word layout
    localparam int TGT_LSB   = 6;
    localparam int SIDE_BIT  = 12;
    localparam int PIECE_LSB = 13;
    localparam int CAP_LSB   = 17;

    // Arithmetic widths: bonus * entry, its magnitude, and the final sum
    localparam int PROD_W = BONUS_W + SCORE_W;
    localparam int DIVD_W = PROD_W - 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam int                 CAPTURE_WEIGHT = 10000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'd27000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // APB register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_QUIET_LIMIT = 1'b0,
        REG_NOISY_LIMIT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        OP_SCORE     = 2'd0,
        OP_UPD_QUIET = 2'd1,
        OP_UPD_CAP   = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_SCORE_Q = 3'd0,
        CMD_SCORE_C = 3'd1,
        CMD_UPD_Q   = 3'd2,
        CMD_UPD_C   = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_BAD     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [QIDX_W-1:0]          q_idx;
        logic [CIDX_W-1:0]          c_idx;
        logic [CODE_W-1:0]          cap;
        logic signed [BONUS_W-1:0]  bonus;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR    = 3'd0,
        ST_IDLE     = 3'd1,
        ST_READ     = 3'd2,
        ST_EXEC     = 3'd3,
        ST_DIV_GO   = 3'd4,
        ST_DIV_WAIT = 3'd5,
        ST_FINISH   = 3'd6,
        ST_DONE     = 3'd7
    } t_state;

endpackage

// ----- rtl/mhst_front.sv -----
module mhst_front (
    input  logic                                  i_valid,
    input  logic [1:0]                            i_operation,
    input  logic [mhst_pkg::MOVE_W-1:0]           i_move_word,
    input  logic signed [mhst_pkg::BONUS_W-1:0]   i_bonus,
    input  logic                                  i_enable,
    output logic                                  o_ready,
    output logic                                  o_push_valid,
    output mhst_pkg::t_cmd                        o_push_cmd,
    input  logic                                  i_push_ready
);

    mhst_pkg::t_op                       op;
    logic [mhst_pkg::TGT_W-1:0]          target;
    logic                                side;
    logic [mhst_pkg::CODE_W-1:0]         piece;
    logic [mhst_pkg::CODE_W-1:0]         cap;
    logic                                piece_ok;
    logic                                cap_ok;
    logic                                use_cap;

    // Handshake: hold off while the tables are being cleared after reset
    assign o_ready      = i_push_ready && i_enable;
    assign o_push_valid = i_valid && i_enable;

    // Unpack the move word
    assign op     = mhst_pkg::t_op'(i_operation);
    assign target = i_move_word[mhst_pkg::TGT_LSB +: mhst_pkg::TGT_W];
    assign side   = i_move_word[mhst_pkg::SIDE_BIT];
    assign piece  = i_move_word[mhst_pkg::PIECE_LSB +: mhst_pkg::CODE_W];
    assign cap    = i_move_word[mhst_pkg::CAP_LSB +: mhst_pkg::CODE_W];

    // Code checks and table selection
    always_comb begin
        piece_ok = (int'(piece) >= 2) && (int'(piece) <= mhst_pkg::PIECE_KINDS + 1);
        cap_ok   = (cap == '0) ||
                   ((int'(cap) >= 2) && (int'(cap) <= mhst_pkg::PIECE_KINDS + 1));
        use_cap  = (op == mhst_pkg::OP_UPD_CAP) || ((op == mhst_pkg::OP_SCORE) && (cap != '0));
        // capture update with nothing captured
        if ((op == mhst_pkg::OP_UPD_CAP) && (cap == '0)) begin
            cap_ok = 1'b0;
        end
        // target off the board for quiet accesses
        if (!use_cap && (int'(target) >= mhst_pkg::NUM_SQUARES)) begin
            piece_ok = 1'b0;
        end
    end

    // Build the command
    always_comb begin
        o_push_cmd.q_idx = mhst_pkg::QIDX_W'((int'(side) * mhst_pkg::PIECE_KINDS
                           + int'(piece) - 2) * mhst_pkg::NUM_SQUARES + int'(target));
        o_push_cmd.c_idx = mhst_pkg::CIDX_W'((int'(side) * mhst_pkg::PIECE_KINDS
                           + int'(piece) - 2) * mhst_pkg::PIECE_KINDS + int'(cap) - 2);
        o_push_cmd.cap   = cap;
        o_push_cmd.bonus = i_bonus;
        case (op)
            mhst_pkg::OP_CLEAR: begin
                o_push_cmd.kind = mhst_pkg::CMD_CLEAR;
            end
            mhst_pkg::OP_SCORE: begin
                if (!piece_ok || !cap_ok) begin
                    o_push_cmd.kind = mhst_pkg::CMD_BAD;
                end else if (use_cap) begin
                    o_push_cmd.kind = mhst_pkg::CMD_SCORE_C;
                end else begin
                    o_push_cmd.kind = mhst_pkg::CMD_SCORE_Q;
                end
            end
            mhst_pkg::OP_UPD_QUIET: begin
                o_push_cmd.kind = (piece_ok && cap_ok) ? mhst_pkg::CMD_UPD_Q
                                                       : mhst_pkg::CMD_BAD;
            end
            mhst_pkg::OP_UPD_CAP: begin
                o_push_cmd.kind = (piece_ok && cap_ok) ? mhst_pkg::CMD_UPD_C
                                                       : mhst_pkg::CMD_BAD;
            end
            default: begin
                o_push_cmd.kind = mhst_pkg::CMD_BAD;
            end
        endcase
    end

endmodule

// ----- rtl/mhst_queue.sv -----
module mhst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  mhst_pkg::t_cmd  i_push_cmd,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output mhst_pkg::t_cmd  o_pop_cmd,
    input  logic            i_pop_ready
);

    mhst_pkg::t_cmd               r_slot [mhst_pkg::QUEUE_DEPTH];
    logic [mhst_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [mhst_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [mhst_pkg::QCNT_W-1:0]  r_count;
    logic [mhst_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [mhst_pkg::QPTR_W-1:0]  n_rd_ptr;
    logic                         push;
    logic                         pop;

    assign o_push_ready = (r_count != mhst_pkg::QCNT_W'(mhst_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == mhst_pkg::QPTR_W'(mhst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == mhst_pkg::QPTR_W'(mhst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : r_rd_ptr + 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/mhst_div.sv -----
module mhst_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mhst_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [mhst_pkg::LIMIT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [mhst_pkg::DIVD_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(mhst_pkg::DIVD_W);

    logic [mhst_pkg::DIVD_W-1:0]   r_quo;
    logic [mhst_pkg::LIMIT_W-1:0]  r_rem;
    logic [mhst_pkg::LIMIT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [mhst_pkg::LIMIT_W:0]    trial;
    logic                          fits;
    logic [mhst_pkg::LIMIT_W:0]    diff;

    // One quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[mhst_pkg::DIVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mhst_pkg::DIVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath; remainder stays below the divisor so it fits LIMIT_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mhst_pkg::DIVD_W-2:0], fits};
            r_rem <= fits ? diff[mhst_pkg::LIMIT_W-1:0] : trial[mhst_pkg::LIMIT_W-1:0];
        end
    end

endmodule

// ----- rtl/mhst_back.sv -----
module mhst_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    input  mhst_pkg::t_cmd                        i_cmd,
    output logic                                  o_cmd_ready,
    input  logic [mhst_pkg::LIMIT_W-1:0]          i_quiet_limit,
    input  logic [mhst_pkg::LIMIT_W-1:0]          i_noisy_limit,
    output logic                                  o_init_busy,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mhst_pkg::SCORE_W-1:0]   o_score,
    output logic                                  o_bad_code
);

    localparam int SW = mhst_pkg::SCORE_W;
    localparam int XW = mhst_pkg::SUM_W;

    // Clamp a wide signed sum into the 32-bit range
    function automatic logic signed [SW-1:0] sat32(input logic signed [XW-1:0] v);
        logic [XW-SW:0] hi;
        hi = v[XW-1:SW-1];
        if ((&hi) || (~|hi)) begin
            return v[SW-1:0];
        end else if (v[XW-1]) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    // Tables
    logic signed [SW-1:0]  r_quiet_mem [mhst_pkg::QUIET_DEPTH];
    logic signed [SW-1:0]  r_cap_mem   [mhst_pkg::CAP_DEPTH];
    logic signed [SW-1:0]  r_q_rd;
    logic signed [SW-1:0]  r_c_rd;

    mhst_pkg::t_state                    r_state, n_state;
    mhst_pkg::t_cmd                      r_cmd, n_cmd;
    logic [mhst_pkg::QIDX_W-1:0]         r_clr_addr, n_clr_addr;
    logic                                r_clr_reply, n_clr_reply;
    logic signed [mhst_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic signed [SW-1:0]                r_entry, n_entry;
    logic signed [SW-1:0]                r_res_score, n_res_score;
    logic                                r_res_bad, n_res_bad;
    logic                                r_out_valid;
    logic signed [SW-1:0]                r_out_score;
    logic                                r_out_bad;

    logic                                wq_en;
    logic [mhst_pkg::QIDX_W-1:0]         wq_addr;
    logic                                wc_en;
    logic [mhst_pkg::CIDX_W-1:0]         wc_addr;
    logic signed [SW-1:0]                wr_data;
    logic                                out_load;

    logic                                is_cap;
    logic signed [SW-1:0]                entry;
    logic [mhst_pkg::LIMIT_W-1:0]        limit;
    logic [mhst_pkg::LIMIT_W-1:0]        divisor;
    logic                                bonus_pos;
    logic signed [XW-1:0]                entry_x;
    logic signed [XW-1:0]                r_entry_x;
    logic signed [XW-1:0]                bonus_x;
    logic signed [XW-1:0]                cap_w;
    logic signed [mhst_pkg::PROD_W-1:0]  prod_c;
    logic [mhst_pkg::PROD_W-1:0]         prod_mag;
    logic                                div_start;
    logic                                div_done;
    logic [mhst_pkg::DIVD_W-1:0]         quotient;
    logic signed [XW-1:0]                quo_x;
    logic signed [XW-1:0]                quo_s;
    logic signed [XW-1:0]                grav_sum;

    // Operand selection and extension
    assign is_cap    = (r_cmd.kind == mhst_pkg::CMD_SCORE_C) || (r_cmd.kind == mhst_pkg::CMD_UPD_C);
    assign entry     = is_cap ? r_c_rd : r_q_rd;
    assign limit     = is_cap ? i_noisy_limit : i_quiet_limit;
    assign divisor   = (limit == '0) ? mhst_pkg::LIMIT_W'(1) : limit;
    assign bonus_pos = !r_cmd.bonus[mhst_pkg::BONUS_W-1] && (r_cmd.bonus != '0);
    assign entry_x   = {{(XW-SW){entry[SW-1]}}, entry};
    assign r_entry_x = {{(XW-SW){r_entry[SW-1]}}, r_entry};
    assign bonus_x   = {{(XW-mhst_pkg::BONUS_W){r_cmd.bonus[mhst_pkg::BONUS_W-1]}}, r_cmd.bonus};
    assign cap_w     = XW'(mhst_pkg::CAPTURE_WEIGHT * int'(r_cmd.cap));
    assign prod_c    = $signed(r_cmd.bonus) * entry;

    // Gravity: magnitude into the divider, sign restored afterwards
    assign prod_mag  = r_prod[mhst_pkg::PROD_W-1] ? -r_prod : r_prod;
    assign quo_x     = {{(XW-mhst_pkg::DIVD_W){1'b0}}, quotient};
    assign quo_s     = r_prod[mhst_pkg::PROD_W-1] ? -quo_x : quo_x;
    assign grav_sum  = r_entry_x + bonus_x - quo_s;

    mhst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_mag[mhst_pkg::DIVD_W-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_prod      = r_prod;
        n_entry     = r_entry;
        n_res_score = r_res_score;
        n_res_bad   = r_res_bad;
        o_cmd_ready = 1'b0;
        wq_en       = 1'b0;
        wc_en       = 1'b0;
        wq_addr     = r_cmd.q_idx;
        wc_addr     = r_cmd.c_idx;
        wr_data     = '0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            mhst_pkg::ST_CLEAR: begin
                // one entry of each table per cycle, the capture table only at addresses below CAP_DEPTH
                wq_en   = 1'b1;
                wq_addr = r_clr_addr;
                wc_en   = (int'(r_clr_addr) < mhst_pkg::CAP_DEPTH);
                wc_addr = r_clr_addr[mhst_pkg::CIDX_W-1:0];
                if (r_clr_addr == mhst_pkg::QIDX_W'(mhst_pkg::QUIET_DEPTH - 1)) begin
                    n_clr_addr  = '0;
                    n_clr_reply = 1'b0;
                    n_res_score = '0;
                    n_res_bad   = 1'b0;
                    n_state     = r_clr_reply ? mhst_pkg::ST_DONE : mhst_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            mhst_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        mhst_pkg::CMD_BAD: begin
                            n_res_score = '0;
                            n_res_bad   = 1'b1;
                            n_state     = mhst_pkg::ST_DONE;
                        end
                        mhst_pkg::CMD_CLEAR: begin
                            n_clr_reply = 1'b1;
                            n_state     = mhst_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = mhst_pkg::ST_READ;
                        end
                    endcase
                end
            end
            mhst_pkg::ST_READ: begin
                n_state = mhst_pkg::ST_EXEC;
            end
            mhst_pkg::ST_EXEC: begin
                n_res_bad = 1'b0;
                case (r_cmd.kind)
                    mhst_pkg::CMD_SCORE_Q: begin
                        n_res_score = entry;
                        n_state     = mhst_pkg::ST_DONE;
                    end
                    mhst_pkg::CMD_SCORE_C: begin
                        n_res_score = sat32(entry_x + cap_w);
                        n_state     = mhst_pkg::ST_DONE;
                    end
                    mhst_pkg::CMD_UPD_Q, mhst_pkg::CMD_UPD_C: begin
                        n_res_score = '0;
                        if (bonus_pos) begin
                            n_prod  = prod_c;
                            n_entry = entry;
                            n_state = mhst_pkg::ST_DIV_GO;
                        end else begin
                            // non-positive bonus is added as is
                            wq_en   = !is_cap;
                            wc_en   = is_cap;
                            wr_data = sat32(entry_x + bonus_x);
                            n_state = mhst_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_state = mhst_pkg::ST_IDLE;
                    end
                endcase
            end
            mhst_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = mhst_pkg::ST_DIV_WAIT;
            end
            mhst_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = mhst_pkg::ST_FINISH;
                end
            end
            mhst_pkg::ST_FINISH: begin
                wq_en   = !is_cap;
                wc_en   = is_cap;
                wr_data = sat32(grav_sum);
                n_state = mhst_pkg::ST_DONE;
            end
            mhst_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = mhst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhst_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_prod      <= n_prod;
        r_entry     <= n_entry;
        r_res_score <= n_res_score;
        r_res_bad   <= n_res_bad;
        if (out_load) begin
            r_out_score <= r_res_score;
            r_out_bad   <= r_res_bad;
        end
    end

    // Table memories, registered read at the current command's index
    always_ff @(posedge i_clk) begin
        if (wq_en) begin
            r_quiet_mem[wq_addr] <= wr_data;
        end
        r_q_rd <= r_quiet_mem[r_cmd.q_idx];
    end

    always_ff @(posedge i_clk) begin
        if (wc_en) begin
            r_cap_mem[wc_addr] <= wr_data;
        end
        r_c_rd <= r_cap_mem[r_cmd.c_idx];
    end

    assign o_init_busy = (r_state == mhst_pkg::ST_CLEAR) && !r_clr_reply;
    assign o_valid     = r_out_valid;
    assign o_score     = r_out_score;
    assign o_bad_code  = r_out_bad;

endmodule

// ----- rtl/move_history_score_table.sv -----
// Sequence: scores and non-positive updates pass through the read, execute and done states
// (flagged codes go straight to done); positive updates also run the 47-step bit-serial divider;
// a clear runs the 768-entry table sweep (one entry a cycle) before its result.
// Throughput: the back end works on one item at a time; a 2-entry queue takes more meanwhile.
// Reset: synchronous, active low; limits return to 27000 and a clearing pass over 768 entries
// zeroes both tables with o_ready low until it ends (register writes are taken throughout).
module move_history_score_table (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_operation,
    input  logic [mhst_pkg::MOVE_W-1:0]           i_move_word,
    input  logic signed [mhst_pkg::BONUS_W-1:0]   i_bonus,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mhst_pkg::SCORE_W-1:0]   o_score,
    output logic                                  o_bad_code,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mhst_pkg::PADDR_W-1:0]          paddr,
    input  logic [mhst_pkg::PDATA_W-1:0]          pwdata,
    output logic [mhst_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    logic [mhst_pkg::LIMIT_W-1:0]  r_quiet_limit;
    logic [mhst_pkg::LIMIT_W-1:0]  r_noisy_limit;
    mhst_pkg::t_reg                reg_sel;
    logic                          cfg_wr;

    logic                          init_busy;
    logic                          push_valid;
    logic                          push_ready;
    mhst_pkg::t_cmd                push_cmd;
    logic                          pop_valid;
    logic                          pop_ready;
    mhst_pkg::t_cmd                pop_cmd;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = mhst_pkg::t_reg'(paddr[mhst_pkg::PADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_limit <= mhst_pkg::LIMIT_RESET;
            r_noisy_limit <= mhst_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                mhst_pkg::REG_QUIET_LIMIT: r_quiet_limit <= pwdata[mhst_pkg::LIMIT_W-1:0];
                mhst_pkg::REG_NOISY_LIMIT: r_noisy_limit <= pwdata[mhst_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            mhst_pkg::REG_QUIET_LIMIT: prdata = mhst_pkg::PDATA_W'(r_quiet_limit);
            mhst_pkg::REG_NOISY_LIMIT: prdata = mhst_pkg::PDATA_W'(r_noisy_limit);
            default:                   prdata = '0;
        endcase
    end

    // Front: classify incoming transfers
    mhst_front u_front (
        .i_valid      (i_valid),
        .i_operation  (i_operation),
        .i_move_word  (i_move_word),
        .i_bonus      (i_bonus),
        .i_enable     (!init_busy),
        .o_ready      (o_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // Command queue
    mhst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    // Back: tables, gravity arithmetic, result register
    mhst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (pop_valid),
        .i_cmd         (pop_cmd),
        .o_cmd_ready   (pop_ready),
        .i_quiet_limit (r_quiet_limit),
        .i_noisy_limit (r_noisy_limit),
        .o_init_busy   (init_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_score       (o_score),
        .o_bad_code    (o_bad_code)
    );

endmodule

// ----- rtl/mhst_checker.sv -----
module mhst_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  o_ready,
    input  logic [1:0]                            i_operation,
    input  logic [mhst_pkg::MOVE_W-1:0]           i_move_word,
    input  logic signed [mhst_pkg::BONUS_W-1:0]   i_bonus,
    input  logic                                  o_valid,
    input  logic                                  i_ready,
    input  logic signed [mhst_pkg::SCORE_W-1:0]   o_score,
    input  logic                                  o_bad_code,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mhst_pkg::PADDR_W-1:0]          paddr,
    input  logic [mhst_pkg::PDATA_W-1:0]          pwdata,
    input  logic [mhst_pkg::PDATA_W-1:0]          prdata,
    input  logic                                  pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_score) && $stable(o_bad_code))
        else $error("result changed while stalled");

    // Flagged codes never carry a score
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_code |-> o_score == '0)
        else $error("nonzero score with bad code");

    // Leaving reset: no result, and no transfer taken as the clearing pass begins
    a_reset_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid && !o_ready)
        else $error("output or ready active right after reset");

    // Readback of the quiet limit after a write
    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(psel && penable && pwrite && (paddr[mhst_pkg::PADDR_W-1] == 1'b0))
        && psel && !pwrite && (paddr[mhst_pkg::PADDR_W-1] == 1'b0)
        |-> prdata == {{(mhst_pkg::PDATA_W-mhst_pkg::LIMIT_W){1'b0}},
                       $past(pwdata[mhst_pkg::LIMIT_W-1:0])})
        else $error("quiet limit readback mismatch");

endmodule

bind move_history_score_table mhst_checker u_mhst_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import mhst_pkg::*;

    // One move request and the outcome the table should return for it
    typedef struct {
        t_op                        op;
        logic [MOVE_W-1:0]          mv;
        logic signed [BONUS_W-1:0]  bonus;
    } t_move_item;

    typedef struct {
        logic signed [SCORE_W-1:0]  score;
        logic                       bad;
    } t_outcome;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_operation = OP_SCORE;
    logic [MOVE_W-1:0]            i_move_word = '0;
    logic signed [BONUS_W-1:0]    i_bonus = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [SCORE_W-1:0]    o_score;
    logic                         o_bad_code;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [PADDR_W-1:0]           paddr = '0;
    logic [PDATA_W-1:0]           pwdata = '0;
    logic [PDATA_W-1:0]           prdata;
    logic                         pready;

    // Shadow copy of the tables and limits
    logic signed [SCORE_W-1:0]    quiet_hist [QUIET_DEPTH];
    logic signed [SCORE_W-1:0]    capture_hist [CAP_DEPTH];
    logic [LIMIT_W-1:0]           quiet_div = LIMIT_RESET;
    logic [LIMIT_W-1:0]           capture_div = LIMIT_RESET;

    t_move_item                   moves_to_send [$];
    t_outcome                     due_results [$];
    t_move_item                   next_move;
    t_outcome                     seen;
    int                           mismatches = 0;
    logic                         steady = 1'b0;

    move_history_score_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_move_word (i_move_word),
        .i_bonus     (i_bonus),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_score     (o_score),
        .o_bad_code  (o_bad_code),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [SCORE_W-1:0] sat32(longint v);
        if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
        return v[SCORE_W-1:0];
    endfunction

    // Gravity: positive bonus decays toward the limit, negative is added as is
    function automatic logic signed [SCORE_W-1:0] pull_entry(
        logic signed [SCORE_W-1:0] entry, logic signed [BONUS_W-1:0] bonus,
        logic [LIMIT_W-1:0] lim);
        longint e;
        longint b;
        longint d;
        e = entry;
        b = bonus;
        d = (lim == '0) ? 64'd1 : {48'd0, lim};
        if (b > 0)
            return sat32(e + b - (b * e) / d);
        return sat32(e + b);
    endfunction

    // Apply one move request to the shadow tables, return the expected outcome
    function automatic t_outcome play_move(t_op op, logic [MOVE_W-1:0] mv,
                                           logic signed [BONUS_W-1:0] bonus);
        int       tgt;
        int       side;
        int       piece;
        int       cap;
        int       idx;
        bit       piece_ok;
        bit       cap_ok;
        bit       use_cap;
        longint   sc;
        t_outcome res;
        tgt   = mv[TGT_LSB +: TGT_W];
        side  = mv[SIDE_BIT];
        piece = mv[PIECE_LSB +: CODE_W];
        cap   = mv[CAP_LSB +: CODE_W];
        sc    = 0;
        res.bad = 1'b0;
        if (op == OP_CLEAR) begin
            foreach (quiet_hist[i]) quiet_hist[i] = '0;
            foreach (capture_hist[i]) capture_hist[i] = '0;
        end else begin
            piece_ok = piece >= 2 && piece <= PIECE_KINDS + 1;
            cap_ok   = cap == 0 || (cap >= 2 && cap <= PIECE_KINDS + 1);
            use_cap  = op == OP_UPD_CAP || (op == OP_SCORE && cap != 0);
            if (op == OP_UPD_CAP && cap == 0) cap_ok = 1'b0;
            if (!use_cap && tgt >= NUM_SQUARES) piece_ok = 1'b0;
            if (!piece_ok || !cap_ok) begin
                res.bad = 1'b1;
            end else if (use_cap) begin
                idx = (side * PIECE_KINDS + piece - 2) * PIECE_KINDS + cap - 2;
                if (op == OP_SCORE)
                    sc = longint'(CAPTURE_WEIGHT) * cap + capture_hist[idx];
                else
                    capture_hist[idx] = pull_entry(capture_hist[idx], bonus, capture_div);
            end else begin
                idx = (side * PIECE_KINDS + piece - 2) * NUM_SQUARES + tgt;
                if (op == OP_SCORE)
                    sc = quiet_hist[idx];
                else
                    quiet_hist[idx] = pull_entry(quiet_hist[idx], bonus, quiet_div);
            end
        end
        res.score = sat32(sc);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Request driver: predict on each transfer, then load the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid)
                due_results.push_back(play_move(t_op'(i_operation), i_move_word, i_bonus));
            if (moves_to_send.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
                next_move = moves_to_send.pop_front();
                i_valid     <= 1'b1;
                i_operation <= next_move.op;
                i_move_word <= next_move.mv;
                i_bonus     <= next_move.bonus;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || $urandom_range(99) >= 13;
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result, score", o_score, 0);
                end else begin
                    seen = due_results.pop_front();
                    if (o_score !== seen.score)
                        report_mismatch("score", o_score, seen.score);
                    if (o_bad_code !== seen.bad)
                        report_mismatch("bad_code", o_bad_code, seen.bad);
                end
            end
        end
    end

    function automatic logic [MOVE_W-1:0] make_move(int tgt, int side, int piece, int cap);
        return {cap[2:0], 1'($urandom), piece[2:0], side[0], tgt[5:0], 6'($urandom)};
    endfunction

    task automatic queue_move(t_op op, logic [MOVE_W-1:0] mv, logic signed [BONUS_W-1:0] b);
        t_move_item it;
        it.op    = op;
        it.mv    = mv;
        it.bonus = b;
        moves_to_send.push_back(it);
    endtask

    // Random request, biased to a few hot entries so updates pile up
    task automatic queue_random_move();
        int       r;
        int       tgt;
        int       piece;
        int       cap;
        t_op      op;
        logic signed [BONUS_W-1:0] b;
        r = $urandom_range(99);
        if (r < 2) op = OP_CLEAR;
        else if (r < 40) op = OP_SCORE;
        else if (r < 70) op = OP_UPD_QUIET;
        else op = OP_UPD_CAP;
        tgt   = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(63);
        piece = ($urandom_range(99) < 92) ? $urandom_range(7, 2) : $urandom_range(7);
        if (op == OP_UPD_CAP || (op == OP_SCORE && $urandom_range(1)))
            cap = ($urandom_range(99) < 92) ? $urandom_range(7, 2) : $urandom_range(7);
        else
            cap = ($urandom_range(99) < 90) ? 0 : $urandom_range(7);
        r = $urandom_range(99);
        if (r < 40) b = 16'($urandom_range(600) - 300);
        else if (r < 70) b = 16'($urandom);
        else if (r < 85) b = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else b = 16'($urandom_range(32767, 1000));
        queue_move(op, make_move(tgt, $urandom_range(1), piece, cap), b);
    endtask

    task automatic wait_drained();
        while (moves_to_send.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write with setup and access phases; the limit takes effect at the access edge
    task automatic write_limit(t_reg which, logic [LIMIT_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_QUIET_LIMIT) quiet_div = val;
        else capture_div = val;
    endtask

    // Walk one entry to the top and bottom of the range (needs limit 1)
    task automatic queue_saturation(t_op upd, logic [MOVE_W-1:0] mv);
        queue_move(upd, mv, -16'sd2);
        repeat (3) queue_move(upd, mv, 16'sh7fff);
        queue_move(OP_SCORE, mv, '0);
        queue_move(upd, mv, 16'sd2);
        queue_move(upd, mv, 16'sh8000);
        queue_move(OP_SCORE, mv, '0);
    endtask

    initial begin
        logic [LIMIT_W-1:0] ql;
        logic [LIMIT_W-1:0] nl;
        foreach (quiet_hist[i]) quiet_hist[i] = '0;
        foreach (capture_hist[i]) capture_hist[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every operation, invalid codes, clear
        queue_move(OP_SCORE, make_move(0, 0, 2, 0), '0);
        queue_move(OP_UPD_QUIET, make_move(0, 0, 2, 0), 16'sh7fff);
        queue_move(OP_SCORE, make_move(0, 0, 2, 0), '0);
        queue_move(OP_UPD_QUIET, make_move(0, 0, 2, 0), 16'sh8000);
        queue_move(OP_SCORE, make_move(0, 0, 2, 0), '0);
        queue_move(OP_UPD_QUIET, make_move(0, 0, 2, 0), '0);
        queue_move(OP_UPD_CAP, make_move(5, 1, 7, 7), 16'sh7fff);
        queue_move(OP_SCORE, make_move(5, 1, 7, 7), '0);
        queue_move(OP_SCORE, make_move(9, 0, 0, 0), '0);
        queue_move(OP_SCORE, make_move(9, 0, 1, 3), '0);
        queue_move(OP_UPD_QUIET, make_move(9, 1, 0, 0), 16'sd100);
        queue_move(OP_SCORE, make_move(9, 0, 4, 1), '0);
        queue_move(OP_UPD_CAP, make_move(9, 0, 4, 0), 16'sd100);
        queue_move(OP_UPD_CAP, make_move(9, 0, 4, 1), 16'sd100);
        queue_move(OP_UPD_QUIET, make_move(9, 0, 4, 1), 16'sd100);
        queue_move(OP_SCORE, make_move(63, 1, 7, 0), '0);
        queue_move(OP_UPD_QUIET, make_move(63, 1, 7, 0), -16'sd1);
        queue_move(OP_SCORE, make_move(63, 1, 7, 0), '0);
        queue_move(OP_CLEAR, make_move(0, 0, 2, 0), '0);
        queue_move(OP_SCORE, make_move(5, 1, 7, 7), '0);
        queue_move(OP_SCORE, make_move(63, 1, 7, 0), '0);
        queue_move(OP_CLEAR, '1, '1);
        wait_drained();

        // Random phases, each with its own limits; the sender holds off between them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin ql = LIMIT_RESET; nl = LIMIT_RESET; end
                1: begin ql = 16'd1;       nl = 16'd1;       end
                2: begin ql = 16'd0;       nl = 16'd0;       end
                3: begin ql = 16'hffff;    nl = 16'hffff;    end
                4: begin ql = 16'hffff;    nl = 16'd1;       end
                default: begin
                    ql = LIMIT_W'($urandom_range(65535, 1));
                    nl = LIMIT_W'($urandom_range(65535, 1));
                end
            endcase
            if (ph != 0) begin
                write_limit(REG_QUIET_LIMIT, ql);
                write_limit(REG_NOISY_LIMIT, nl);
            end
            steady = (ph == 1);
            if (ph == 1) begin
                queue_saturation(OP_UPD_QUIET, make_move(17, 1, 6, 0));
                queue_saturation(OP_UPD_CAP, make_move(17, 0, 7, 7));
            end
            repeat (220) queue_random_move();
            wait_drained();
        end
        steady = 1'b0;

        repeat (800) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mhst_pkg.sv
rtl/mhst_front.sv
rtl/mhst_queue.sv
rtl/mhst_div.sv
rtl/mhst_back.sv
rtl/move_history_score_table.sv
rtl/mhst_checker.sv
sim/tb.sv
